// ----- hdl/mzt_pkg.sv -----
// shared types and constants for the multi-zone timeout timer
package mzt_pkg;

  // default number of zones
  localparam int ZONE_COUNT_DEF = 4;

  // zones that appear in the event masks
  localparam int MASK_W = 4;

  // field widths
  localparam int TICK_W   = 32;
  localparam int CNT_W    = 16;
  localparam int BOOST_W  = 20;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // one tick is 100 ms
  localparam logic [BOOST_W-1:0] TICK_MS = BOOST_W'(100);

  // ms to ticks: floor(v / 100) == (v * 83887) >> 23 for any 16-bit v
  localparam int LIM_W = 10;
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(83887);
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W = CFG_W + RECIP_W;
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(15000 / 100);

  // action codes
  localparam logic [1:0] ACT_TICK100 = 2'd0;
  localparam logic [1:0] ACT_TICK1S  = 2'd1;
  localparam logic [1:0] ACT_SYNC    = 2'd2;

  // zone mode codes
  localparam logic [1:0] MODE_SELECTING = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTING_TIMEOUT = 1'b1;

  // input transaction
  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         zone;
    logic [1:0]         zone_mode;
    logic               boost_on;
    logic               setting_on;
    logic               countdown_on;
    logic [CNT_W-1:0]   countdown_seconds;
    logic [TICK_W-1:0]  select_snapshot;
    logic [TICK_W-1:0]  setting_snapshot;
    logic [BOOST_W-1:0] boost_left_ms;
  } mzt_in_t;

  // result transaction
  typedef struct packed {
    logic [MASK_W-1:0] select_fired;
    logic [MASK_W-1:0] setting_fired;
    logic [MASK_W-1:0] boost_fired;
    logic [MASK_W-1:0] expired_fired;
    logic [TICK_W-1:0] tick_now;
  } mzt_out_t;

  // per-zone command from the top level
  typedef struct packed {
    logic tick100;
    logic tick1s;
    logic sync;
  } zone_ctl_t;

  // per-zone events
  typedef struct packed {
    logic sel;
    logic set;
    logic bst;
    logic exp;
  } zone_evt_t;

endpackage

// ----- hdl/mzt_cfg.sv -----
// configuration registers, held as timeout limits in ticks
module mzt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [mzt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mzt_pkg::CFG_W-1:0]        cfg_wdata,
  output logic [mzt_pkg::LIM_W-1:0]        sel_lim,
  output logic [mzt_pkg::LIM_W-1:0]        set_lim
);

  logic [mzt_pkg::PROD_W-1:0] prod;
  logic [mzt_pkg::LIM_W-1:0]  lim_next;

  // divide by 100 through the reciprocal
  always_comb begin
    prod = mzt_pkg::PROD_W'(cfg_wdata) * mzt_pkg::PROD_W'(mzt_pkg::RECIP_MUL);
    lim_next = prod[mzt_pkg::RECIP_SHIFT +: mzt_pkg::LIM_W];
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_lim <= mzt_pkg::LIM_RESET;
      set_lim <= mzt_pkg::LIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mzt_pkg::REG_SELECT_TIMEOUT:  sel_lim <= lim_next;
        mzt_pkg::REG_SETTING_TIMEOUT: set_lim <= lim_next;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/mzt_zone.sv -----
// state and timeout checks of one zone
module mzt_zone (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  mzt_pkg::zone_ctl_t            ctl,
  input  logic [mzt_pkg::TICK_W-1:0]    tick_new,
  input  logic [mzt_pkg::LIM_W-1:0]     sel_lim,
  input  logic [mzt_pkg::LIM_W-1:0]     set_lim,
  input  mzt_pkg::mzt_in_t              sync_data,
  output mzt_pkg::zone_evt_t            evt
);

  logic [1:0]                    mode;
  logic                          boost_flag;
  logic                          setting_flag;
  logic                          countdown_flag;
  logic [mzt_pkg::CNT_W-1:0]     countdown;
  logic [mzt_pkg::TICK_W-1:0]    select_mark;
  logic [mzt_pkg::TICK_W-1:0]    setting_mark;
  logic [mzt_pkg::BOOST_W-1:0]   boost_left;

  logic [mzt_pkg::TICK_W-1:0]    sel_elapsed;
  logic [mzt_pkg::TICK_W-1:0]    set_elapsed;
  logic                          boost_out;
  logic                          count_live;

  // timeout checks
  always_comb begin
    sel_elapsed = tick_new - select_mark;
    set_elapsed = tick_new - setting_mark;
    boost_out   = (boost_left <= mzt_pkg::TICK_MS);
    count_live  = countdown_flag && (countdown != '0);
    evt.sel = ctl.tick100 && (mode == mzt_pkg::MODE_SELECTING) &&
              (sel_elapsed >= mzt_pkg::TICK_W'(sel_lim));
    evt.set = ctl.tick100 && setting_flag &&
              (set_elapsed >= mzt_pkg::TICK_W'(set_lim));
    evt.bst = ctl.tick100 && boost_flag && boost_out;
    evt.exp = ctl.tick1s && count_live && (countdown == mzt_pkg::CNT_W'(1));
  end

  // zone state update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= '0;
      boost_flag     <= 1'b0;
      setting_flag   <= 1'b0;
      countdown_flag <= 1'b0;
      countdown      <= '0;
      select_mark    <= '0;
      setting_mark   <= '0;
      boost_left     <= '0;
    end else if (en) begin
      if (ctl.sync) begin
        mode           <= sync_data.zone_mode;
        boost_flag     <= sync_data.boost_on;
        setting_flag   <= sync_data.setting_on;
        countdown_flag <= sync_data.countdown_on;
        countdown      <= sync_data.countdown_seconds;
        select_mark    <= sync_data.select_snapshot;
        setting_mark   <= sync_data.setting_snapshot;
        boost_left     <= sync_data.boost_left_ms;
      end
      if (evt.sel) begin
        select_mark <= tick_new;
      end
      if (evt.set) begin
        setting_mark <= tick_new;
      end
      if (ctl.tick100 && boost_flag) begin
        boost_left <= boost_out ? '0 : boost_left - mzt_pkg::TICK_MS;
      end
      if (ctl.tick1s && count_live) begin
        countdown <= countdown - mzt_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/multi_zone_timeout_timer.sv -----
// top level of the multi-zone timeout timer
//
// Usage: items enter on the in_valid/in_ready channel as one mzt_in_t
// transaction: a 100 ms tick, a one-second tick or a sync of one zone's
// cached state. Each item gives exactly one mzt_out_t transaction on the
// out_valid/out_ready channel with the per-zone event masks and the tick
// counter after the item.
// An accepted item is held in the input register, then all zones update in
// parallel into the result register, which raises out_valid. Throughput is
// one item per cycle while the receiver does not stall; the zone state is
// written at the same edge as the result, so the next item sees it at once.
// When the receiver stalls, the result register holds and the input
// register takes one more item before in_ready drops.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while
// no transaction is in flight; limits are converted to ticks on write.
// Reset (rst, synchronous) clears the tick counter, all zone state and
// both pipeline stages, and sets both timeouts to 15000 ms.
module multi_zone_timeout_timer #(
  parameter int ZONE_COUNT = mzt_pkg::ZONE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mzt_pkg::mzt_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mzt_pkg::mzt_out_t             out_data,
  input  logic                          cfg_wr_en,
  input  logic [mzt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mzt_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                          s1_valid;
  mzt_pkg::mzt_in_t              s1_data;
  logic                          advance;
  logic                          commit;
  logic [mzt_pkg::TICK_W-1:0]    tick_count;
  logic [mzt_pkg::TICK_W-1:0]    tick_new;
  logic [mzt_pkg::LIM_W-1:0]     sel_lim;
  logic [mzt_pkg::LIM_W-1:0]     set_lim;
  logic                          is_tick100;
  logic                          is_tick1s;
  logic                          is_sync;
  mzt_pkg::zone_evt_t            evt [ZONE_COUNT];
  mzt_pkg::mzt_out_t             out_next;

  // handshake
  assign advance  = !out_valid || out_ready;
  assign commit   = s1_valid && advance;
  assign in_ready = !s1_valid || advance;
  assign tick_new = tick_count + mzt_pkg::TICK_W'(1);

  // action decode
  always_comb begin
    is_tick100 = 1'b0;
    is_tick1s  = 1'b0;
    is_sync    = 1'b0;
    unique case (s1_data.action)
      mzt_pkg::ACT_TICK100: is_tick100 = 1'b1;
      mzt_pkg::ACT_TICK1S:  is_tick1s  = 1'b1;
      mzt_pkg::ACT_SYNC:    is_sync    = 1'b1;
      default: ;
    endcase
  end

  mzt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sel_lim   (sel_lim),
    .set_lim   (set_lim)
  );

  // zone array
  for (genvar z = 0; z < ZONE_COUNT; z++) begin : g_zone
    mzt_pkg::zone_ctl_t ctl;
    assign ctl.tick100 = is_tick100;
    assign ctl.tick1s  = is_tick1s;
    assign ctl.sync    = is_sync && (32'(s1_data.zone) == 32'(z));

    mzt_zone u_zone (
      .clk       (clk),
      .rst       (rst),
      .en        (commit),
      .ctl       (ctl),
      .tick_new  (tick_new),
      .sel_lim   (sel_lim),
      .set_lim   (set_lim),
      .sync_data (s1_data),
      .evt       (evt[z])
    );
  end

  // collect masks of the low zones
  always_comb begin
    out_next = '0;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      if (z < mzt_pkg::MASK_W) begin
        out_next.select_fired[z]  = evt[z].sel;
        out_next.setting_fired[z] = evt[z].set;
        out_next.boost_fired[z]   = evt[z].bst;
        out_next.expired_fired[z] = evt[z].exp;
      end
    end
    out_next.tick_now = is_tick100 ? tick_new : tick_count;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // tick counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (commit && is_tick100) begin
        tick_count <= tick_new;
      end
    end
    if (commit) begin
      out_data <= out_next;
    end
  end

endmodule
